>>> rtl/close_payload_utf8_checker_core_assert.svh
// Assertion macros for the close payload checker.
// Used by the top level only; needs clk and rst in the including scope.
`ifndef CLOSE_PAYLOAD_UTF8_CHECKER_CORE_ASSERT_SVH
`define CLOSE_PAYLOAD_UTF8_CHECKER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPUC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("close payload check failed");

// The consequent must hold in the cycle after the antecedent.
`define CPUC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("close payload check failed");

`endif

>>> rtl/cpuc_pkg.sv
// Shared types, codes and the UTF-8 step function of the close payload checker.
// No dependencies.
package cpuc_pkg;

  localparam int COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [COUNT_W-1:0] HEADER_BYTES = 17'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNCATED = 3'd1;
  localparam logic [2:0] ST_VERSION   = 3'd2;
  localparam logic [2:0] ST_REASON    = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_LENGTH    = 3'd5;
  localparam logic [2:0] ST_UTF8      = 3'd6;

  localparam logic REG_VERSION  = 1'b0;
  localparam logic REG_MAX_TEXT = 1'b1;

  localparam logic [7:0] REASON_MAX = 8'd6;

  typedef struct packed {
    logic [7:0]  expected_version;
    logic [15:0] max_text_bytes;
  } cfg_t;

  typedef struct packed {
    logic        text_valid;
    logic [7:0]  text_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [7:0]  close_reason;
    logic [15:0] text_length;
  } out_word_t;

  typedef struct packed {
    logic [1:0] pend;
    logic       bad;
  } utf8_t;

  // One byte of the lax UTF-8 decoder: returns the new pending count and
  // whether this byte broke the sequence.
  function automatic utf8_t utf8_step(input logic [7:0] b, input logic [1:0] pend);
    utf8_t r;
    r.pend = 2'd0;
    r.bad  = 1'b0;
    if (pend != 2'd0) begin
      if ((b & 8'hC0) != 8'h80) begin
        r.bad = 1'b1;
      end else begin
        r.pend = pend - 2'd1;
      end
    end else if (b <= 8'h7F) begin
      r.pend = 2'd0;
    end else if ((b & 8'hE0) == 8'hC0 && b >= 8'hC2) begin
      r.pend = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      r.pend = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0 && b <= 8'hF4) begin
      r.pend = 2'd3;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> rtl/cpuc_in_stage.sv
// Input register of the close payload checker.
// Holds one accepted word until the evaluation stage takes it; no package use.
module cpuc_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  input  logic       take,
  output logic       full,
  output logic [7:0] held_byte,
  output logic       held_last
);

  logic accept;

  assign in_stall = full && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= data_byte;
      held_last <= is_last;
    end
  end

endmodule

>>> rtl/cpuc_eval.sv
// Payload state, status evaluation and result register of the checker.
// Depends on cpuc_pkg for codes, types and the UTF-8 step.
module cpuc_eval (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_full,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  cpuc_pkg::cfg_t      cfg,
  input  logic                out_stall,
  output logic                take,
  output logic                out_full,
  output cpuc_pkg::out_word_t res
);

  logic [cpuc_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic        version_bad, version_bad_next;
  logic [7:0]  reason_value, reason_value_next;
  logic [15:0] length_value, length_value_next;
  logic [1:0]  pending_continuations, pending_next;
  logic        utf8_bad, utf8_bad_next;
  cpuc_pkg::utf8_t     u8;
  cpuc_pkg::out_word_t res_next;
  logic        is_text;

  assign take    = in_full && (!out_full || !out_stall);
  assign is_text = byte_count >= cpuc_pkg::HEADER_BYTES;
  assign u8      = cpuc_pkg::utf8_step(in_byte, pending_continuations);

  always_comb begin
    version_bad_next  = version_bad;
    reason_value_next = reason_value;
    length_value_next = length_value;
    pending_next      = pending_continuations;
    utf8_bad_next     = utf8_bad;
    case (byte_count)
      17'd0:   version_bad_next = in_byte != cfg.expected_version;
      17'd1:   reason_value_next = in_byte;
      17'd2:   length_value_next = {in_byte, 8'h00};
      17'd3:   length_value_next = {length_value[15:8], in_byte};
      default: begin
        pending_next  = u8.pend;
        utf8_bad_next = utf8_bad || u8.bad;
      end
    endcase
    byte_count_next = (byte_count < cpuc_pkg::COUNT_MAX) ? byte_count + 1'b1 : byte_count;
  end

  always_comb begin
    res_next.text_valid   = is_text;
    res_next.text_byte    = is_text ? in_byte : 8'h00;
    res_next.done_res     = in_last;
    res_next.status       = cpuc_pkg::ST_OK;
    res_next.close_reason = 8'h00;
    res_next.text_length  = 16'h0000;
    if (in_last) begin
      // The count after this byte is the payload's total length.
      if (byte_count_next < cpuc_pkg::HEADER_BYTES) begin
        res_next.status = cpuc_pkg::ST_TRUNCATED;
      end else if (version_bad_next) begin
        res_next.status = cpuc_pkg::ST_VERSION;
      end else if (reason_value_next == 8'h00 || reason_value_next > cpuc_pkg::REASON_MAX) begin
        res_next.status = cpuc_pkg::ST_REASON;
      end else if (length_value_next > cfg.max_text_bytes) begin
        res_next.status = cpuc_pkg::ST_TOO_LARGE;
      end else if (byte_count_next != cpuc_pkg::HEADER_BYTES + {1'b0, length_value_next}) begin
        res_next.status = cpuc_pkg::ST_LENGTH;
      end else if (utf8_bad_next || pending_next != 2'd0) begin
        res_next.status = cpuc_pkg::ST_UTF8;
      end
      if (byte_count_next >= cpuc_pkg::HEADER_BYTES) begin
        res_next.text_length = length_value_next;
      end
      if (res_next.status == cpuc_pkg::ST_OK) begin
        res_next.close_reason = reason_value_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count            <= '0;
      version_bad           <= 1'b0;
      reason_value          <= 8'h00;
      length_value          <= 16'h0000;
      pending_continuations <= 2'd0;
      utf8_bad              <= 1'b0;
    end else if (take) begin
      if (in_last) begin
        byte_count            <= '0;
        version_bad           <= 1'b0;
        reason_value          <= 8'h00;
        length_value          <= 16'h0000;
        pending_continuations <= 2'd0;
        utf8_bad              <= 1'b0;
      end else begin
        byte_count            <= byte_count_next;
        version_bad           <= version_bad_next;
        reason_value          <= reason_value_next;
        length_value          <= length_value_next;
        pending_continuations <= pending_next;
        utf8_bad              <= utf8_bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (take) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

>>> rtl/close_payload_utf8_checker_core.sv
// Top level of the close payload checker: configuration registers, input
// register, evaluation stage and assertions. Depends on cpuc_pkg and the
// assertion header.

// Checks a session-closing payload streamed one byte per word: version, reason,
// big-endian text length, then UTF-8 diagnostic text that is echoed out. Every
// accepted byte gives one result word, and the final byte carries the status.
// The block takes one byte per cycle while the output is not stalled; a result
// passes through the input register, then the result register, and that rate
// is set by the single payload state update between those registers.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
`include "close_payload_utf8_checker_core_assert.svh"

module close_payload_utf8_checker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        text_valid,
  output logic [7:0]  text_byte,
  output logic        done_res,
  output logic [2:0]  status,
  output logic [7:0]  close_reason,
  output logic [15:0] text_length
);

  cpuc_pkg::cfg_t      cfg;
  cpuc_pkg::out_word_t res;
  logic                take;
  logic                held_full;
  logic [7:0]          held_byte;
  logic                held_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version <= 8'd1;
      cfg.max_text_bytes   <= 16'd1024;
    end else if (cfg_write) begin
      case (cfg_index)
        cpuc_pkg::REG_VERSION:  cfg.expected_version <= cfg_data[7:0];
        cpuc_pkg::REG_MAX_TEXT: cfg.max_text_bytes   <= cfg_data;
        default: ;
      endcase
    end
  end

  cpuc_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .is_last   (is_last),
    .take      (take),
    .full      (held_full),
    .held_byte (held_byte),
    .held_last (held_last)
  );

  cpuc_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .in_full   (held_full),
    .in_byte   (held_byte),
    .in_last   (held_last),
    .cfg       (cfg),
    .out_stall (out_stall),
    .take      (take),
    .out_full  (out_valid),
    .res       (res)
  );

  assign text_valid   = res.text_valid;
  assign text_byte    = res.text_byte;
  assign done_res     = res.done_res;
  assign status       = res.status;
  assign close_reason = res.close_reason;
  assign text_length  = res.text_length;

  // The input side only backs up when a result is waiting and blocked.
  `CPUC_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)
  `CPUC_ASSERT_IMPL(a_status_on_done, out_valid && !done_res, status == cpuc_pkg::ST_OK)
  `CPUC_ASSERT_IMPL(a_reason_only_ok, out_valid && status != cpuc_pkg::ST_OK, close_reason == 8'h00)
  `CPUC_ASSERT_NEXT(a_take_fills_out, take, out_valid)

endmodule

>>> verif/close_payload_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class for the close payload checker testbench: predicts one result
// word per accepted byte and checks the words that leave the block.
// Depends on cpuc_pkg for the result layout, status codes and register indexes.
package close_payload_tb_pkg;
  import cpuc_pkg::*;

  class close_status_board;
    cfg_t               regs;
    logic [COUNT_W-1:0] seen;
    logic               ver_bad;
    logic [7:0]         reason;
    logic [15:0]        decl_len;
    logic [1:0]         pend;
    logic               utf8_bad;
    out_word_t          predicted[$];
    int unsigned        mismatches;

    function new();
      regs.expected_version = 8'd1;
      regs.max_text_bytes   = 16'd1024;
      mismatches = 0;
      clear_payload();
    endfunction

    function void clear_payload();
      seen     = '0;
      ver_bad  = 1'b0;
      reason   = 8'h00;
      decl_len = 16'h0000;
      pend     = 2'd0;
      utf8_bad = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [15:0] data);
      if (idx == REG_VERSION) begin
        regs.expected_version = data[7:0];
      end else begin
        regs.max_text_bytes = data;
      end
    endfunction

    // Lax decoder: a missing continuation marks the text bad and drops the
    // open sequence without reading the byte as a new lead.
    function void scan_text(logic [7:0] b);
      if (pend != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          utf8_bad = 1'b1;
          pend = 2'd0;
        end else begin
          pend = pend - 2'd1;
        end
      end else if (!b[7]) begin
        pend = 2'd0;
      end else if (b[7:5] == 3'b110 && b >= 8'hC2) begin
        pend = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        pend = 2'd2;
      end else if (b[7:3] == 5'b11110 && b <= 8'hF4) begin
        pend = 2'd3;
      end else begin
        utf8_bad = 1'b1;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      out_word_t          w;
      logic [COUNT_W-1:0] idx;
      idx = seen;
      w = '0;
      case (idx)
        17'd0: ver_bad = (b != regs.expected_version);
        17'd1: reason = b;
        17'd2: decl_len = {b, 8'h00};
        17'd3: decl_len[7:0] = b;
        default: scan_text(b);
      endcase
      if (seen != COUNT_MAX) seen = seen + 1'b1;
      w.text_valid = (idx >= HEADER_BYTES);
      w.text_byte  = w.text_valid ? b : 8'h00;
      w.done_res   = last;
      if (last) begin
        if (seen < HEADER_BYTES) w.status = ST_TRUNCATED;
        else if (ver_bad) w.status = ST_VERSION;
        else if (reason == 8'h00 || reason > REASON_MAX) w.status = ST_REASON;
        else if (decl_len > regs.max_text_bytes) w.status = ST_TOO_LARGE;
        else if (seen != HEADER_BYTES + {1'b0, decl_len}) w.status = ST_LENGTH;
        else if (utf8_bad || pend != 2'd0) w.status = ST_UTF8;
        else w.status = ST_OK;
        if (seen >= HEADER_BYTES) w.text_length = decl_len;
        if (w.status == ST_OK) w.close_reason = reason;
        clear_payload();
      end
      predicted = {predicted, w};
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (predicted.size() == 0) begin
        $error("result word arrived with no byte waiting for it");
        mismatches++;
        return;
      end
      want = predicted.pop_front();
      cmp_field("text_valid", want.text_valid, got.text_valid);
      cmp_field("text_byte", want.text_byte, got.text_byte);
      cmp_field("done_res", want.done_res, got.done_res);
      cmp_field("status", want.status, got.status);
      cmp_field("close_reason", want.close_reason, got.close_reason);
      cmp_field("text_length", want.text_length, got.text_length);
    endfunction
  endclass

endpackage

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the close payload checker testbench: clock, reset, byte and result
// drivers, register writes and the final verdict. Depends on cpuc_pkg and
// close_payload_tb_pkg.
module tb_top;
  import cpuc_pkg::*;
  import close_payload_tb_pkg::*;

  typedef logic [7:0] payload_t[$];

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        is_last;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        text_valid;
  logic [7:0]  text_byte;
  logic        done_res;
  logic [2:0]  status;
  logic [7:0]  close_reason;
  logic [15:0] text_length;

  close_status_board board;
  out_word_t         seen_word;
  logic [7:0]        cur_version;
  logic [15:0]       cur_max;
  bit                send_calm = 1'b0;
  bit                recv_calm = 1'b0;

  close_payload_utf8_checker_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .text_valid(text_valid), .text_byte(text_byte), .done_res(done_res),
    .status(status), .close_reason(close_reason), .text_length(text_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) board.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) board.note_byte(data_byte, is_last);
      if (out_valid && !out_stall) begin
        seen_word = '{text_valid, text_byte, done_res, status, close_reason, text_length};
        board.check_word(seen_word);
      end
    end
  end

  function automatic logic [7:0] lead_byte(int k);
    case (k)
      1: return 8'($urandom_range(8'h00, 8'h7F));
      2: return 8'($urandom_range(8'hC2, 8'hDF));
      3: return 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'hF0, 8'hF4));
    endcase
  endfunction

  // Mostly well-formed payloads for the current registers, with a share of
  // truncated noise, header faults, broken text and wrong lengths.
  function automatic payload_t make_payload();
    payload_t    p;
    payload_t    text;
    int          kind;
    int          n;
    int          k;
    int          room;
    logic [7:0]  ver;
    logic [7:0]  rsn;
    logic [15:0] decl;
    n = $urandom_range(0, (cur_max < 12) ? int'(cur_max) : 12);
    while (text.size() < n) begin
      room = n - text.size();
      k = $urandom_range(1, (room < 4) ? room : 4);
      text = {text, lead_byte(k)};
      repeat (k - 1) text = {text, 8'($urandom_range(8'h80, 8'hBF))};
    end
    ver  = cur_version;
    rsn  = 8'($urandom_range(1, 6));
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      repeat ($urandom_range(1, 3)) p = {p, 8'($urandom)};
      return p;
    end
    if (kind < 10) begin
      ver = cur_version ^ 8'($urandom_range(1, 255));
    end else if (kind < 15) begin
      rsn = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(7, 255));
    end else if (kind < 22) begin
      // Leave a multibyte sequence open at the end of the text.
      k = $urandom_range(2, 4);
      text = {text, lead_byte(k)};
      repeat ($urandom_range(0, k - 2)) text = {text, 8'($urandom_range(8'h80, 8'hBF))};
    end else if (kind < 30) begin
      if (text.size() == 0) text = {text, 8'($urandom_range(8'h80, 8'hFF))};
      else text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
    end
    decl = 16'(text.size());
    if (kind >= 30 && kind < 37) begin
      if (decl == 16'd0 || $urandom_range(0, 1) == 1) decl = decl + 16'($urandom_range(1, 3));
      else decl = decl - 16'd1;
    end else if (kind >= 37 && kind < 42) begin
      decl = 16'($urandom);
    end
    p = {ver, rsn, decl[15:8], decl[7:0]};
    p = {p, text};
    return p;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    is_last   <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_payload(input payload_t p);
    foreach (p[i]) send_byte(p[i], i == p.size() - 1);
  endtask

  // The block is idle once the last word is out, so settle waits until the
  // scoreboard expects no more words.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.predicted.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(input logic [7:0] ver, input logic [15:0] maxt);
    cfg_write <= 1'b1;
    cfg_index <= REG_VERSION;
    cfg_data  <= {8'($urandom), ver};
    @(negedge clk);
    cfg_index <= REG_MAX_TEXT;
    cfg_data  <= maxt;
    @(negedge clk);
    cfg_write   <= 1'b0;
    cur_version = ver;
    cur_max     = maxt;
  endtask

  initial begin : drain
    int gap;
    forever begin
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      gap = recv_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    payload_t    dq;
    int          phase_items;
    logic [7:0]  v;
    logic [15:0] m;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_VERSION;
    cfg_data  = 16'h0000;
    in_valid  = 1'b0;
    data_byte = 8'h00;
    is_last   = 1'b0;
    board     = new();
    cur_version = 8'd1;
    cur_max     = 16'd1024;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed payloads under the reset register values.
    dq = {8'h01};
    send_payload(dq);
    dq = {8'h01, 8'h06, 8'h00, 8'h03, 8'hE2, 8'h82, 8'hAC};
    send_payload(dq);
    dq = {8'hFF, 8'h01, 8'h00, 8'h00};
    send_payload(dq);
    dq = {8'h01, 8'h00, 8'h00, 8'h00};
    send_payload(dq);
    dq = {8'h01, 8'h02, 8'h04, 8'h01};
    send_payload(dq);
    dq = {8'h01, 8'h03, 8'h00, 8'h01, 8'hFF};
    send_payload(dq);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          v = 8'h00;
          m = 16'h0000;
        end
        1: begin
          v = 8'hFF;
          m = 16'hFFFF;
        end
        2: begin
          v = 8'h01;
          m = 16'd1024;
        end
        default: begin
          v = 8'($urandom);
          m = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 16)) : 16'($urandom);
        end
      endcase
      write_regs(v, m);
      phase_items = 0;
      while (phase_items < 110) begin
        dq = make_payload();
        send_payload(dq);
        phase_items += dq.size();
      end
      settle();
    end

    if (board.mismatches == 0 && board.predicted.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> close_payload_utf8_checker_core.f
+incdir+rtl
rtl/cpuc_pkg.sv
rtl/cpuc_in_stage.sv
rtl/cpuc_eval.sv
rtl/close_payload_utf8_checker_core.sv
verif/close_payload_tb_pkg.sv
verif/tb_top.sv
